// ===== design/rcpwd_pkg.sv =====
package rcpwd_pkg;

   // Field and register widths.
   localparam int unsigned TIME_W     = 16;
   localparam int unsigned COUNT_W    = 8;
   localparam int unsigned THROTTLE_W = 11;
   localparam int unsigned WEIGHT_W   = 4;
   localparam int unsigned CSR_W      = 16;

   // Pulse width scaling: the timer width is taken in units of 32 ticks.
   localparam int unsigned TICK_SHIFT = 5;
   localparam logic [THROTTLE_W-1:0] PULSE_OFFSET = 11'd280;

   // Reset value of the overflow period register.
   localparam logic [TIME_W-1:0] PERIOD_RESET = 16'd256;

   // Averaging filter divider: numerator and remainder widths, step count.
   localparam int unsigned NUM_W     = 15;
   localparam int unsigned REM_W     = WEIGHT_W;
   localparam int unsigned DIV_CNT_W = 4;
   localparam logic [DIV_CNT_W-1:0] DIV_STEPS = 4'(NUM_W);

   // Input word operation codes.
   localparam logic OP_TICK    = 1'b0;
   localparam logic OP_CAPTURE = 1'b1;

   // Configuration register indexes.
   localparam logic CSR_FILTER_WEIGHT   = 1'b0;
   localparam logic CSR_OVERFLOW_PERIOD = 1'b1;

   // Sequencer states.
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_SUM  = 5'b00010,
      ST_STEP = 5'b00100,
      ST_DIV  = 5'b01000,
      ST_EMIT = 5'b10000
   } state_type;

endpackage

// ===== design/rc_pulse_width_decoder.sv =====
// Channel  Direction  Ports                               Word
// req      in         req_valid, req_ready                req_operation, req_capture_time
// rsp      out        rsp_valid, rsp_ready                rsp_throttle
// csr      in         csr_wr_en, csr_index, csr_wdata     filter_weight, overflow_period
//
// Overflow ticks and rising-edge captures are taken while idle and give no word.
// A falling-edge capture passes through the width sum, the step and filter multiply,
// the restoring divider (only with filtering on), and the load of the output register.
// req_ready is low until the sequencer is back in idle.
// A word still waiting in the output register holds the sequencer in its final load,
// with req_ready low; while the sequencer is idle, other words are still taken.
// Reset is synchronous and active high; it resets the control registers, not the datapath registers.
module rc_pulse_width_decoder (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_operation,
   input  logic [rcpwd_pkg::TIME_W-1:0]     req_capture_time,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic [rcpwd_pkg::THROTTLE_W-1:0] rsp_throttle,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [rcpwd_pkg::CSR_W-1:0]      csr_wdata
);

   // Control and architectural state.
   rcpwd_pkg::state_type state_ff, state_in;
   logic                                await_ff, await_in;
   logic [rcpwd_pkg::TIME_W-1:0]        start_ff, start_in;
   logic [rcpwd_pkg::COUNT_W-1:0]       count_ff, count_in;
   logic [rcpwd_pkg::THROTTLE_W-1:0]    held_ff, held_in;
   logic [rcpwd_pkg::WEIGHT_W-1:0]      weight_ff, weight_in;
   logic [rcpwd_pkg::TIME_W-1:0]        period_ff, period_in;
   logic                                rsp_valid_ff, rsp_valid_in;
   logic [rcpwd_pkg::DIV_CNT_W-1:0]     cnt_ff, cnt_in;

   // Datapath registers.
   logic [rcpwd_pkg::TIME_W-1:0]        cap_ff, cap_in;
   logic [rcpwd_pkg::THROTTLE_W-1:0]    width_ff, width_in;
   logic [rcpwd_pkg::NUM_W-1:0]         quo_ff, quo_in;
   logic [rcpwd_pkg::REM_W-1:0]         rem_ff, rem_in;
   logic [rcpwd_pkg::THROTTLE_W-1:0]    rsp_throttle_ff, rsp_throttle_in;

   // Combinational helpers.
   logic                                req_fire;
   logic [rcpwd_pkg::TIME_W+rcpwd_pkg::COUNT_W-1:0] ovf_ticks;
   logic [rcpwd_pkg::TIME_W-1:0]        raw_width;
   logic [rcpwd_pkg::THROTTLE_W-1:0]    val;
   logic [rcpwd_pkg::THROTTLE_W-1:0]    held_step;
   logic [rcpwd_pkg::NUM_W-1:0]         weighted;
   logic [rcpwd_pkg::REM_W:0]           divisor;
   logic [rcpwd_pkg::REM_W:0]           shifted;
   logic [rcpwd_pkg::REM_W:0]           trial;

   assign req_ready    = (state_ff == rcpwd_pkg::ST_IDLE);
   assign req_fire     = req_valid && req_ready;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_throttle = rsp_throttle_ff;

   // Width of the pulse in timer ticks, wrapped to the timer width.
   assign ovf_ticks = count_ff * period_ff;
   assign raw_width = cap_ff - start_ff + ovf_ticks[rcpwd_pkg::TIME_W-1:0];

   // Clamp and offset, then move the held throttle one step toward the new value.
   assign val = (width_ff < rcpwd_pkg::PULSE_OFFSET) ? '0 : width_ff - rcpwd_pkg::PULSE_OFFSET;
   always_comb begin
      if (held_ff < val) begin
         held_step = held_ff + 1'b1;
      end else if (held_ff > val) begin
         held_step = held_ff - 1'b1;
      end else begin
         held_step = held_ff;
      end
   end
   assign weighted = rcpwd_pkg::NUM_W'(held_step) * rcpwd_pkg::NUM_W'(weight_ff);

   // One restoring division step per cycle by the filter weight plus one.
   assign divisor = {1'b0, weight_ff} + 1'b1;
   assign shifted = {rem_ff, quo_ff[rcpwd_pkg::NUM_W-1]};
   assign trial   = shifted - divisor;

   // Sequencer and next-state logic.
   always_comb begin
      state_in        = state_ff;
      await_in        = await_ff;
      start_in        = start_ff;
      count_in        = count_ff;
      held_in         = held_ff;
      weight_in       = weight_ff;
      period_in       = period_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_ready;
      rsp_throttle_in = rsp_throttle_ff;
      cnt_in          = cnt_ff;
      cap_in          = cap_ff;
      width_in        = width_ff;
      quo_in          = quo_ff;
      rem_in          = rem_ff;

      if (csr_wr_en) begin
         case (csr_index)
            rcpwd_pkg::CSR_FILTER_WEIGHT: begin
               weight_in = csr_wdata[rcpwd_pkg::WEIGHT_W-1:0];
            end
            rcpwd_pkg::CSR_OVERFLOW_PERIOD: begin
               period_in = csr_wdata[rcpwd_pkg::TIME_W-1:0];
            end
            default: begin
            end
         endcase
      end

      case (state_ff)
         rcpwd_pkg::ST_IDLE: begin
            if (req_fire) begin
               if (req_operation == rcpwd_pkg::OP_TICK) begin
                  count_in = count_ff + 1'b1;
               end else if (!await_ff) begin
                  count_in = '0;
                  start_in = req_capture_time;
                  await_in = 1'b1;
               end else begin
                  await_in = 1'b0;
                  cap_in   = req_capture_time;
                  state_in = rcpwd_pkg::ST_SUM;
               end
            end
         end
         rcpwd_pkg::ST_SUM: begin
            width_in = raw_width[rcpwd_pkg::TIME_W-1:rcpwd_pkg::TICK_SHIFT];
            state_in = rcpwd_pkg::ST_STEP;
         end
         rcpwd_pkg::ST_STEP: begin
            if (weight_ff == '0) begin
               quo_in   = rcpwd_pkg::NUM_W'(val);
               state_in = rcpwd_pkg::ST_EMIT;
            end else begin
               quo_in   = weighted + rcpwd_pkg::NUM_W'(val);
               rem_in   = '0;
               cnt_in   = rcpwd_pkg::DIV_STEPS;
               state_in = rcpwd_pkg::ST_DIV;
            end
         end
         rcpwd_pkg::ST_DIV: begin
            if (shifted >= divisor) begin
               rem_in = trial[rcpwd_pkg::REM_W-1:0];
               quo_in = {quo_ff[rcpwd_pkg::NUM_W-2:0], 1'b1};
            end else begin
               rem_in = shifted[rcpwd_pkg::REM_W-1:0];
               quo_in = {quo_ff[rcpwd_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_in = cnt_ff - 1'b1;
            if (cnt_ff == 4'd1) begin
               state_in = rcpwd_pkg::ST_EMIT;
            end
         end
         rcpwd_pkg::ST_EMIT: begin
            // Load the output register once the previous word has left.
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_valid_in    = 1'b1;
               rsp_throttle_in = quo_ff[rcpwd_pkg::THROTTLE_W-1:0];
               held_in         = quo_ff[rcpwd_pkg::THROTTLE_W-1:0];
               state_in        = rcpwd_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rcpwd_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rcpwd_pkg::ST_IDLE;
         await_ff     <= 1'b0;
         start_ff     <= '0;
         count_ff     <= '0;
         held_ff      <= '0;
         weight_ff    <= '0;
         period_ff    <= rcpwd_pkg::PERIOD_RESET;
         rsp_valid_ff <= 1'b0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         await_ff     <= await_in;
         start_ff     <= start_in;
         count_ff     <= count_in;
         held_ff      <= held_in;
         weight_ff    <= weight_in;
         period_ff    <= period_in;
         rsp_valid_ff <= rsp_valid_in;
         cnt_ff       <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      cap_ff          <= cap_in;
      width_ff        <= width_in;
      quo_ff          <= quo_in;
      rem_ff          <= rem_in;
      rsp_throttle_ff <= rsp_throttle_in;
   end

`ifndef ASSERT_OFF
   // A falling-edge capture rearms the rising-edge wait.
   a_falling_rearms: assert property (@(posedge clock) disable iff (reset)
      (req_fire && req_operation == rcpwd_pkg::OP_CAPTURE && await_ff) |=> !await_ff)
      else $error("falling capture did not clear the edge wait");

   // The divider remainder stays below the divisor.
   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcpwd_pkg::ST_DIV) |-> ({1'b0, rem_ff} < divisor))
      else $error("divider remainder out of range");

   // The divider step count never runs out while dividing.
   a_div_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == rcpwd_pkg::ST_DIV) |-> (cnt_ff != '0))
      else $error("divider step count underflow");

   // Every output word lies within the throttle range.
   a_throttle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_throttle_ff <= 11'd1767))
      else $error("throttle out of range");
`endif

endmodule
